FILE: design/asrw_pkg.sv
// Shared types, sizes and SPS byte tables for the Annex B SPS rewriter.
`timescale 1ns / 1ps
`default_nettype none

package asrw_pkg;

    localparam int WIN_DEPTH = 20;
    localparam int OLD_LEN   = 16;
    localparam int NEW_LEN   = 19;
    localparam int GROWTH    = 3;
    localparam int FILL_W    = 5;
    localparam int EMIT_W    = 5;
    localparam int COUNT_W   = 12;
    localparam int ROOM_W    = 16;

    localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(WIN_DEPTH);
    localparam logic [FILL_W-1:0]  FILL_OLD  = FILL_W'(OLD_LEN);
    localparam logic [EMIT_W-1:0]  EMIT_LAST = EMIT_W'(NEW_LEN - 1);
    localparam logic [ROOM_W-1:0]  ROOM_STEP = ROOM_W'(GROWTH);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [7:0] OLD_SPS [OLD_LEN] = '{
        8'h67, 8'h64, 8'h0C, 8'h20, 8'hAC, 8'h2B, 8'h40, 8'h28,
        8'h02, 8'hDD, 8'h35, 8'h01, 8'h0D, 8'h01, 8'hE0, 8'h80
    };

    localparam logic [7:0] NEW_SPS [NEW_LEN] = '{
        8'h67, 8'h64, 8'h0C, 8'h20, 8'hAC, 8'h2B, 8'h40, 8'h28,
        8'h02, 8'hDD, 8'h35, 8'h01, 8'h0D, 8'h01, 8'hE1, 8'hB4,
        8'h11, 8'h08, 8'hD4
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               out_last;
        logic [COUNT_W-1:0] rewrite_count;
    } out_word_t;

endpackage

`default_nettype wire

FILE: design/asrw_match.sv
// Head-of-window SPS match with start code and NAL boundary check.
`timescale 1ns / 1ps
`default_nettype none

module asrw_match
    import asrw_pkg::*;
(
    input  wire logic [7:0]        win [WIN_DEPTH],
    input  wire logic [FILL_W-1:0] fill,
    input  wire logic [7:0]        hist [3],
    input  wire logic [1:0]        hist_fill,
    input  wire logic              at_end,
    output logic                   hit
);

    logic              body_ok;
    logic              start_ok;
    logic [FILL_W-1:0] rem;
    logic              sc3;
    logic              sc4;

    always_comb
    begin
        body_ok = 1'b1;
        for (int i = 0; i < OLD_LEN; i++)
        begin
            if (win[i] != OLD_SPS[i])
                body_ok = 1'b0;
        end
    end

    assign start_ok = (hist_fill == 2'd3) && (hist[0] == 8'h00) &&
                      (hist[1] == 8'h00) && (hist[2] == 8'h01);
    assign rem = fill - FILL_OLD;

    // three or four byte start code right behind the SPS
    assign sc3 = (rem >= FILL_W'(3)) && (win[16] == 8'h00) && (win[17] == 8'h00) &&
                 (win[18] == 8'h01);
    assign sc4 = (rem >= FILL_W'(4)) && (win[16] == 8'h00) && (win[17] == 8'h00) &&
                 (win[18] == 8'h00) && (win[19] == 8'h01);

    always_comb
    begin
        hit = 1'b0;
        if ((fill >= FILL_OLD) && (fill <= FILL_FULL) && start_ok && body_ok)
        begin
            if (at_end && (rem == '0))
                hit = 1'b1;
            else if (sc3 || sc4)
                hit = 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: design/asrw_outbuf.sv
// One-word output register on the valid/ready result channel.
`timescale 1ns / 1ps
`default_nettype none

module asrw_outbuf
    import asrw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire out_word_t load_data,
    output logic           can_load,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_data
);

    logic      valid_reg;
    out_word_t data_reg;

    // slot is free when empty or being taken this cycle
    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_load)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
            data_reg <= load_data;
    end

endmodule

`default_nettype wire

FILE: design/annexb_sps_pattern_rewriter_core.sv
// Top level of the Annex B low-delay SPS rewriter.
//
// Input words (in_valid/in_ready, in_data) carry one stream byte and a mark on
// the final byte of a buffer. Output words (out_valid/out_ready, out_data) carry
// the rewritten stream; rewrite_count is set on the word with out_last.
// spare_bytes is to be written through spare_bytes_we/spare_bytes only while
// idle, which the block does not enforce; it is loaded as free room on the
// first byte of each buffer. Bytes sit in a 20-byte look-ahead window: the first
// output word is registered once the window is full or the final byte has
// arrived. Throughput is one byte per cycle outside the stalls below; the window
// shift and the output register both move one word a cycle. A rewrite emits 19
// bytes for 16 consumed, so input stalls while the replacement SPS drains.
// After the final byte, input is held off until the window is flushed.
// Reset empties the window and history and clears room, count and spare_bytes.
// When the receiver stalls, the output register holds its word and the
// window stops shifting, so input stalls once the window is full.
`timescale 1ns / 1ps
`default_nettype none

module annexb_sps_pattern_rewriter_core
    import asrw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              spare_bytes_we,
    input  wire logic [ROOM_W-1:0] spare_bytes,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_word_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_word_t              out_data
);

    logic [ROOM_W-1:0]  spare_reg;
    logic [7:0]         win_reg [WIN_DEPTH];
    logic [7:0]         win_next [WIN_DEPTH];
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [7:0]         hist_reg [3];
    logic [1:0]         hist_fill_reg;
    logic [ROOM_W-1:0]  room_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               flush_reg;
    logic               emit_reg;
    logic [EMIT_W-1:0]  emit_idx_reg;

    logic               can_load;
    logic               hit_raw;
    logic               hit;
    logic               decide_ok;
    logic               do_emit;
    logic               do_decide;
    logic               rewrite;
    logic               pop1;
    logic               prod;
    logic               is_last;
    logic               accept;
    logic [FILL_W-1:0]  fill_after;
    logic [7:0]         prod_byte;
    out_word_t          prod_word;

    asrw_match u_match (
        .win       (win_reg),
        .fill      (fill_reg),
        .hist      (hist_reg),
        .hist_fill (hist_fill_reg),
        .at_end    (flush_reg),
        .hit       (hit_raw)
    );

    asrw_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (prod),
        .load_data (prod_word),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign hit       = hit_raw && (room_reg >= ROOM_STEP);
    assign decide_ok = !emit_reg && ((fill_reg == FILL_FULL) || (flush_reg && fill_reg != '0));
    assign do_emit   = emit_reg && can_load;
    assign do_decide = decide_ok && can_load;
    assign rewrite   = do_decide && hit;
    assign pop1      = do_decide && !hit;
    assign prod      = do_emit || do_decide;

    assign in_ready  = !flush_reg && ((fill_reg < FILL_FULL) || do_decide);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        if (rewrite)
            fill_after = fill_reg - FILL_OLD;
        else if (pop1)
            fill_after = fill_reg - FILL_W'(1);
        else
            fill_after = fill_reg;
    end

    assign fill_next = fill_after + FILL_W'(accept);

    always_comb
    begin
        if (do_emit)
            prod_byte = NEW_SPS[emit_idx_reg];
        else if (hit)
            prod_byte = NEW_SPS[0];
        else
            prod_byte = win_reg[0];
    end

    assign count_next = (rewrite && count_reg != COUNT_MAX) ? count_reg + COUNT_W'(1)
                                                            : count_reg;

    // final word: last pass-through byte, or tail of a replacement that emptied the window
    assign is_last = flush_reg && ((do_emit && emit_idx_reg == EMIT_LAST && fill_reg == '0) ||
                                   (pop1 && fill_reg == FILL_W'(1)));

    always_comb
    begin
        prod_word.out_byte      = prod_byte;
        prod_word.out_last      = is_last;
        prod_word.rewrite_count = is_last ? count_next : '0;
    end

    // advance window by one or sixteen, then append the accepted byte
    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            if (rewrite && (i + OLD_LEN < WIN_DEPTH))
                win_next[i] = win_reg[i + OLD_LEN];
            else if (pop1 && (i + 1 < WIN_DEPTH))
                win_next[i] = win_reg[i + 1];
            else
                win_next[i] = win_reg[i];
            if (accept && (fill_after == FILL_W'(i)))
                win_next[i] = in_data.data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        if (prod)
        begin
            hist_reg[0] <= hist_reg[1];
            hist_reg[1] <= hist_reg[2];
            hist_reg[2] <= prod_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spare_reg     <= '0;
            fill_reg      <= '0;
            hist_fill_reg <= '0;
            room_reg      <= '0;
            count_reg     <= '0;
            flush_reg     <= 1'b0;
            emit_reg      <= 1'b0;
            emit_idx_reg  <= '0;
        end
        else
        begin
            if (spare_bytes_we)
                spare_reg <= spare_bytes;

            fill_reg  <= fill_next;
            count_reg <= count_next;

            if (accept && fill_reg == '0 && hist_fill_reg == '0)
                room_reg <= spare_reg;
            else if (rewrite)
                room_reg <= room_reg - ROOM_STEP;

            if (prod && hist_fill_reg != 2'd3)
                hist_fill_reg <= hist_fill_reg + 2'd1;

            if (accept && in_data.last_byte)
                flush_reg <= 1'b1;

            if (rewrite)
            begin
                emit_reg     <= 1'b1;
                emit_idx_reg <= EMIT_W'(1);
            end
            else if (do_emit)
            begin
                emit_idx_reg <= emit_idx_reg + EMIT_W'(1);
                if (emit_idx_reg == EMIT_LAST)
                    emit_reg <= 1'b0;
            end

            // drop buffer state once the flush is done
            if (is_last)
            begin
                flush_reg     <= 1'b0;
                hist_fill_reg <= '0;
                room_reg      <= '0;
                count_reg     <= '0;
            end
        end
    end

endmodule

`default_nettype wire
